/* rtl/bitmap_frame_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the cycle after ante
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante followed by cons");

// Check that cond never holds
`define BFA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: forbidden condition");

`else

`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define BFA_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Transaction types, function codes and fixed constants of the allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int FRAME_W    = 21;
    localparam int WORD_BITS  = 32;

    localparam logic [FRAME_W-1:0] TOTAL_RESET = 21'd32768;

    // Function codes
    localparam logic [2:0] FUNC_MARK_ALL = 3'd0;
    localparam logic [2:0] FUNC_RELEASE  = 3'd1;
    localparam logic [2:0] FUNC_RESERVE  = 3'd2;
    localparam logic [2:0] FUNC_ALLOC    = 3'd3;
    localparam logic [2:0] FUNC_FREE     = 3'd4;
    localparam logic [2:0] FUNC_QUERY    = 3'd5;

    // Query answers
    localparam logic signed [1:0] QS_FREE  = 2'sb00;
    localparam logic signed [1:0] QS_USED  = 2'sb01;
    localparam logic signed [1:0] QS_RANGE = 2'sb11;
    localparam logic signed [1:0] QS_BAD   = 2'sb10;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] byte_addr;
        logic [19:0] first_frame;
        logic [20:0] end_frame;
    } t_in_item;

    typedef struct packed {
        logic [31:0]       alloc_addr;
        logic signed [1:0] query_state;
        logic [20:0]       used_count;
    } t_out_item;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_stat;

endpackage

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module bfa_ram import bfa_pkg::*; #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data arrives in the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bfa_seq.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator sequencer
// Walks bitmap words through the memory: fill sweep, range read-modify-write,
// first-fit scan, single word query. Keeps the used frame count.
// ----------------------------------------------------------------------------
module bfa_seq import bfa_pkg::*; #(
    parameter int MAX_FRAMES = 32768,
    parameter int IDX_W      = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  t_in_item               i_item,
    input  logic [FRAME_W-1:0]     i_lim,
    input  logic                   i_res_ready,
    output t_seq_stat              o_stat,
    output t_out_item              o_res,
    output logic                   o_rd_en,
    output logic [IDX_W-1:0]       o_rd_addr,
    input  logic [WORD_BITS-1:0]   i_rd_data,
    output logic                   o_wr_en,
    output logic [IDX_W-1:0]       o_wr_addr,
    output logic [WORD_BITS-1:0]   o_wr_data
);

    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(WORDS - 1);
    localparam logic [FRAME_W-1:0] RESET_LIM =
        (TOTAL_RESET > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES) : TOTAL_RESET;
    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_QUERY = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Count of ones in a word, as an adder tree
    function automatic logic [5:0] popcount32(input logic [31:0] w);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
        for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

    // Position of the lowest clear bit
    function automatic logic [4:0] lowest_zero(input logic [31:0] w);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (!w[i]) pos = 5'(i);
        end
        return pos;
    endfunction

    // Count step up, saturating at the top of the field
    function automatic logic [FRAME_W-1:0] sat_add(input logic [FRAME_W-1:0] a,
                                                    input logic [5:0] k);
        logic [FRAME_W:0] sum;
        sum = {1'b0, a} + (FRAME_W+1)'(k);
        return sum[FRAME_W] ? {FRAME_W{1'b1}} : sum[FRAME_W-1:0];
    endfunction

    // Count step down, saturating at zero
    function automatic logic [FRAME_W-1:0] sat_sub(input logic [FRAME_W-1:0] a,
                                                    input logic [5:0] k);
        return (a < FRAME_W'(k)) ? '0 : a - FRAME_W'(k);
    endfunction

    logic [2:0]           r_state,      n_state;
    logic [IDX_W-1:0]     r_rd_idx,     n_rd_idx;
    logic [IDX_W-1:0]     r_last,       n_last;
    logic [IDX_W-1:0]     r_first_idx,  n_first_idx;
    logic [IDX_W-1:0]     r_pend_idx,   n_pend_idx;
    logic                 r_issue,      n_issue;
    logic                 r_pend,       n_pend;
    logic [4:0]           r_lo_bit,     n_lo_bit;
    logic [4:0]           r_hi_bit,     n_hi_bit;
    logic                 r_reserve,    n_reserve;
    logic                 r_clr_op,     n_clr_op;
    logic [FRAME_W-1:0]   r_used_total, n_used_total;
    logic [31:0]          r_res_addr,   n_res_addr;
    logic signed [1:0]    r_res_qs,     n_res_qs;

    // Start decode
    logic [FRAME_W-1:0]   s_first;
    logic [FRAME_W-1:0]   s_end;
    logic [FRAME_W-1:0]   s_end_c;
    logic [FRAME_W-1:0]   s_end_m1;
    logic [FRAME_W-1:0]   s_lim_m1;
    logic                 s_empty;

    // Word processing
    logic [WORD_BITS-1:0] w_lo_mask;
    logic [WORD_BITS-1:0] w_hi_mask;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_chg;
    logic [5:0]           w_k;
    logic [4:0]           w_zero_bit;
    logic [FRAME_W-1:0]   w_cand;

    always_comb begin
        s_first  = (i_item.func == FUNC_FREE) ?
                   {1'b0, i_item.byte_addr[31:PAGE_SHIFT]} : {1'b0, i_item.first_frame};
        s_end    = (i_item.func == FUNC_FREE) ?
                   {1'b0, i_item.byte_addr[31:PAGE_SHIFT]} + FRAME_W'(1) : i_item.end_frame;
        s_end_c  = (s_end > i_lim) ? i_lim : s_end;
        s_end_m1 = s_end_c - FRAME_W'(1);
        s_lim_m1 = i_lim - FRAME_W'(1);
        s_empty  = (s_first >= s_end_c);
    end

    always_comb begin
        w_lo_mask  = (r_pend_idx == r_first_idx) ? (ALL_ONES << r_lo_bit) : ALL_ONES;
        w_hi_mask  = (r_pend_idx == r_last) ? (ALL_ONES >> (5'd31 - r_hi_bit)) : ALL_ONES;
        w_mask     = w_lo_mask & w_hi_mask;
        w_chg      = r_reserve ? (w_mask & ~i_rd_data) : (w_mask & i_rd_data);
        w_k        = popcount32(w_chg);
        w_zero_bit = lowest_zero(i_rd_data);
        w_cand     = FRAME_W'({r_pend_idx, w_zero_bit});
    end

    // Next state and memory access
    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_last       = r_last;
        n_first_idx  = r_first_idx;
        n_pend_idx   = r_pend_idx;
        n_issue      = r_issue;
        n_pend       = 1'b0;
        n_lo_bit     = r_lo_bit;
        n_hi_bit     = r_hi_bit;
        n_reserve    = r_reserve;
        n_clr_op     = r_clr_op;
        n_used_total = r_used_total;
        n_res_addr   = r_res_addr;
        n_res_qs     = r_res_qs;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_rd_idx;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_pend_idx;
        o_wr_data    = i_rd_data;

        // Issue the next word read while a walk is open
        if ((r_state == S_WALK || r_state == S_SCAN || r_state == S_QUERY) && r_issue) begin
            o_rd_en    = 1'b1;
            n_rd_idx   = r_rd_idx + IDX_W'(1);
            n_issue    = (r_rd_idx != r_last);
            n_pend     = 1'b1;
            n_pend_idx = r_rd_idx;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_rd_idx;
                o_wr_data = ALL_ONES;
                n_rd_idx  = r_rd_idx + IDX_W'(1);
                if (r_rd_idx == LAST_WORD) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_res_addr = '0;
                    n_res_qs   = QS_FREE;
                    n_issue    = 1'b0;
                    unique case (i_item.func)
                        FUNC_MARK_ALL: begin
                            n_used_total = i_lim;
                            n_rd_idx     = '0;
                            n_clr_op     = 1'b1;
                            n_state      = S_CLEAR;
                        end
                        FUNC_RELEASE, FUNC_RESERVE, FUNC_FREE: begin
                            if (s_empty) begin
                                n_state = S_DONE;
                            end else begin
                                n_rd_idx    = s_first[IDX_W+4:5];
                                n_first_idx = s_first[IDX_W+4:5];
                                n_last      = s_end_m1[IDX_W+4:5];
                                n_lo_bit    = s_first[4:0];
                                n_hi_bit    = s_end_m1[4:0];
                                n_reserve   = (i_item.func == FUNC_RESERVE);
                                n_issue     = 1'b1;
                                n_state     = S_WALK;
                            end
                        end
                        FUNC_ALLOC: begin
                            if (i_lim == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_rd_idx = '0;
                                n_last   = s_lim_m1[IDX_W+4:5];
                                n_issue  = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        FUNC_QUERY: begin
                            if ({1'b0, i_item.first_frame} >= i_lim) begin
                                n_res_qs = QS_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_rd_idx = i_item.first_frame[IDX_W+4:5];
                                n_last   = i_item.first_frame[IDX_W+4:5];
                                n_lo_bit = i_item.first_frame[4:0];
                                n_issue  = 1'b1;
                                n_state  = S_QUERY;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Set or clear the in-range bits, count only those that flip
                if (r_pend) begin
                    o_wr_en      = 1'b1;
                    o_wr_data    = r_reserve ? (i_rd_data | w_mask) : (i_rd_data & ~w_mask);
                    n_used_total = r_reserve ? sat_add(r_used_total, w_k)
                                             : sat_sub(r_used_total, w_k);
                    if (r_pend_idx == r_last) begin
                        n_issue = 1'b0;
                        n_pend  = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // Stop at the first word with a clear bit, or after the last word
                if (r_pend) begin
                    if (i_rd_data != ALL_ONES) begin
                        if (w_cand < i_lim) begin
                            o_wr_en      = 1'b1;
                            o_wr_data    = i_rd_data | (WORD_BITS'(1) << w_zero_bit);
                            n_used_total = sat_add(r_used_total, 6'd1);
                            n_res_addr   = 32'(w_cand) << PAGE_SHIFT;
                        end
                        n_issue = 1'b0;
                        n_pend  = 1'b0;
                        n_state = S_DONE;
                    end else if (r_pend_idx == r_last) begin
                        n_issue = 1'b0;
                        n_pend  = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_QUERY: begin
                if (r_pend) begin
                    n_res_qs = i_rd_data[r_lo_bit] ? QS_USED : QS_FREE;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_clr_op = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_rd_idx     <= '0;
            r_issue      <= 1'b0;
            r_pend       <= 1'b0;
            r_clr_op     <= 1'b0;
            r_used_total <= RESET_LIM;
        end else begin
            r_state      <= n_state;
            r_rd_idx     <= n_rd_idx;
            r_issue      <= n_issue;
            r_pend       <= n_pend;
            r_clr_op     <= n_clr_op;
            r_used_total <= n_used_total;
        end
    end

    // Walk bounds and result payload
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_first_idx <= n_first_idx;
        r_pend_idx  <= n_pend_idx;
        r_lo_bit    <= n_lo_bit;
        r_hi_bit    <= n_hi_bit;
        r_reserve   <= n_reserve;
        r_res_addr  <= n_res_addr;
        r_res_qs    <= n_res_qs;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);

    assign o_res.alloc_addr  = r_res_addr;
    assign o_res.query_state = r_res_qs;
    assign o_res.used_count  = r_used_total;

endmodule

/* rtl/bitmap_frame_allocator.sv */
// Bitmap page frame allocator, first fit. One used bit per 4 KiB frame sits
// in a word memory of ceil(MAX_FRAMES/32) entries; the sequencer reads,
// modifies and writes back one word per cycle. After reset the block runs a
// fill pass over every word that marks every frame used; input transactions
// are held off until it ends. Mark all used runs the same fill pass; release,
// reserve and free walk the words that the clipped range touches (free
// touches one); allocate scans the words up to the first one with a clear
// bit; query reads one word; an empty range, an out-of-range query or free,
// an allocate with a zero frame count and an unused code go straight to the
// result. The memory's single read port and single write port set the one
// word per cycle walk. The next transaction is accepted while the previous
// result waits in the output register. The frame count register may only be
// written while the block is idle.
// ----------------------------------------------------------------------------
// Bitmap frame allocator top level
// Handshakes, frame count register, output register and the memory.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_macros.svh"

module bitmap_frame_allocator import bfa_pkg::*; #(
    parameter int MAX_FRAMES = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FRAME_W-1:0] i_cfg_frame_count
);

    localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [FRAME_W-1:0]   r_frame_count;
    logic [FRAME_W-1:0]   w_lim;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item;
    t_seq_stat            w_stat;
    t_out_item            w_res;
    logic                 w_res_ready;
    logic                 w_start;
    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr;
    logic [WORD_BITS-1:0] w_rd_data;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [WORD_BITS-1:0] w_wr_data;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= TOTAL_RESET;
        end else if (i_cfg_valid) begin
            r_frame_count <= i_cfg_frame_count;
        end
    end

    // Effective frame count, saturated to the bitmap size
    assign w_lim = (r_frame_count > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                         : r_frame_count;

    // Input side
    assign o_in_ready = w_stat.idle;
    assign w_start    = i_in_valid && o_in_ready;

    // Output register, refilled in the cycle it drains
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_stat.res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.res_valid && w_res_ready) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bfa_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .IDX_W      (IDX_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (i_in_item),
        .i_lim       (w_lim),
        .i_res_ready (w_res_ready),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    bfa_ram #(
        .DEPTH  (WORDS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Leave idle right after a transaction is taken
    `BFA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_start, !o_in_ready)
    // A finished result is never pending while the sequencer takes new work
    `BFA_ASSERT_NEVER(a_idle_no_result, i_clk, i_rst_n, w_stat.idle && w_stat.res_valid)
    // A handed-over result shows up on the output
    `BFA_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_stat.res_valid && w_res_ready, o_out_valid)
    // Query answer never carries the unused code
    `BFA_ASSERT_NEVER(a_query_code, i_clk, i_rst_n, o_out_valid && o_out_item.query_state == QS_BAD)

endmodule

/* sim/bfa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator result checker
// Watches the request, result and frame count channels of the allocator,
// keeps its own copy of the frame bitmap and used count, and compares every
// result transaction field by field with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; #(
    parameter int MAX_FRAMES = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_item          i_out_item,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [FRAME_W-1:0] i_cfg_frame_count,
    output int                 o_pending,
    output int                 o_fail_count
);

    localparam int NWORDS = (MAX_FRAMES + 31) / 32;

    logic [31:0]        frame_words [NWORDS];
    logic [FRAME_W-1:0] used_cnt;
    logic [FRAME_W-1:0] cfg_frames;
    t_out_item          frame_op_results [$];
    int                 fail_count = 0;
    t_out_item          want;

    assign o_fail_count = fail_count;

    // Clip the register to the frames the bitmap can hold
    function automatic int frame_limit(input logic [FRAME_W-1:0] total);
        return (int'(total) > MAX_FRAMES) ? MAX_FRAMES : int'(total);
    endfunction

    task automatic fill_frames();
        foreach (frame_words[w])
            frame_words[w] = '1;
    endtask

    // Move the used count one step, saturating at both ends
    task automatic bump_used(input logic up);
        if (up) begin
            if (used_cnt != '1)
                used_cnt = used_cnt + 1'b1;
        end else begin
            if (used_cnt != '0)
                used_cnt = used_cnt - 1'b1;
        end
    endtask

    // Set or clear every in-range frame of [first, stop)
    task automatic walk_frames(input int first, input int stop, input logic reserve);
        int f;
        int lim;
        lim = frame_limit(cfg_frames);
        if (stop > lim)
            stop = lim;
        for (f = first; f < stop; f++) begin
            if (frame_words[f / 32][f % 32] != reserve) begin
                frame_words[f / 32][f % 32] = reserve;
                bump_used(reserve);
            end
        end
    endtask

    // Apply one request to the bitmap and work out its result
    task automatic run_frame_op(input t_in_item op, output t_out_item res);
        int lim;
        int f;
        res = '0;
        lim = frame_limit(cfg_frames);
        case (op.func)
            FUNC_MARK_ALL: begin
                fill_frames();
                used_cnt = FRAME_W'(lim);
            end
            FUNC_RELEASE: walk_frames(op.first_frame, op.end_frame, 1'b0);
            FUNC_RESERVE: walk_frames(op.first_frame, op.end_frame, 1'b1);
            FUNC_ALLOC: begin
                // First fit; skip words that are fully used
                for (f = 0; f < lim; f++) begin
                    if (frame_words[f / 32] == '1) begin
                        f = f | 31;
                        continue;
                    end
                    if (!frame_words[f / 32][f % 32]) begin
                        frame_words[f / 32][f % 32] = 1'b1;
                        bump_used(1'b1);
                        res.alloc_addr = 32'(f) << PAGE_SHIFT;
                        break;
                    end
                end
            end
            FUNC_FREE: begin
                f = int'(op.byte_addr >> PAGE_SHIFT);
                if (f < lim && frame_words[f / 32][f % 32]) begin
                    frame_words[f / 32][f % 32] = 1'b0;
                    bump_used(1'b0);
                end
            end
            FUNC_QUERY: begin
                if (int'(op.first_frame) >= lim)
                    res.query_state = QS_RANGE;
                else if (frame_words[op.first_frame / 32][op.first_frame % 32])
                    res.query_state = QS_USED;
                else
                    res.query_state = QS_FREE;
            end
            default: ;
        endcase
        res.used_count = used_cnt;
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        fail_count++;
        $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
    endtask

    // Track the register, check results, then queue the answer of a new request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_frames();
            cfg_frames = TOTAL_RESET;
            used_cnt   = FRAME_W'(frame_limit(TOTAL_RESET));
            frame_op_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                cfg_frames = i_cfg_frame_count;
            if (i_out_valid && i_out_ready) begin
                if (frame_op_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing outstanding, got %h",
                             $time, i_out_item);
                end else begin
                    want = frame_op_results.pop_front();
                    if (i_out_item.alloc_addr !== want.alloc_addr)
                        note_mismatch("alloc_addr", want.alloc_addr, i_out_item.alloc_addr);
                    if (i_out_item.query_state !== want.query_state)
                        note_mismatch("query_state", want.query_state,
                                      i_out_item.query_state);
                    if (i_out_item.used_count !== want.used_count)
                        note_mismatch("used_count", want.used_count, i_out_item.used_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                run_frame_op(i_in_item, want);
                frame_op_results.push_back(want);
            end
        end
        o_pending <= frame_op_results.size();
    end

endmodule

/* sim/tb_bitmap_frame_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives directed corner requests and then random request mixes across a
// series of frame count settings, with random gaps on both channels; the
// checker module compares results and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int MAX_FRAMES   = 32768;
    localparam int GAP_MAX      = 16;
    localparam int IDLE_LIMIT   = 8000;
    localparam int PHASE_ITEMS  = 160;
    localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_B = 3'd7;
    localparam logic [FRAME_W-1:0] END_MAX = 21'h100000;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_item          out_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [FRAME_W-1:0] cfg_total = TOTAL_RESET;

    int                 pending;
    int                 fail_count;
    logic [FRAME_W-1:0] total_now  = TOTAL_RESET;
    bit                 in_burst   = 1'b0;
    bit                 out_burst  = 1'b0;
    int                 out_hold   = 0;
    int                 idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    bitmap_frame_allocator #(
        .MAX_FRAMES(MAX_FRAMES)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_in_item          (in_item),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_out_item         (out_item),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_frame_count  (cfg_total)
    );

    bfa_checker #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_result_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_in_item          (in_item),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_out_item         (out_item),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_frame_count  (cfg_total),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    // Stall the result channel for a random number of cycles after each transaction
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end else if (out_hold > 0) begin
            out_hold  <= out_hold - 1;
            out_ready <= (out_hold == 1);
        end else if (out_valid && out_ready) begin
            if ($urandom_range(0, 31) == 0)
                out_burst <= !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, GAP_MAX);
            out_hold  <= stall;
            out_ready <= (stall == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // End the run when no channel has moved a transaction for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_in_item frame_op(input logic [2:0] func, input logic [31:0] phys,
                                          input logic [19:0] first,
                                          input logic [FRAME_W-1:0] stop);
        t_in_item op;
        op.func        = func;
        op.byte_addr   = phys;
        op.first_frame = first;
        op.end_frame   = stop;
        return op;
    endfunction

    // Mostly low frames so allocation finds them quickly, some anywhere
    function automatic logic [19:0] pick_frame(input int lim);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 20'($urandom_range(0, ((lim < 512) ? lim : 512) + 4));
        if (sel < 8)
            return 20'($urandom_range(0, lim + 4));
        return 20'($urandom);
    endfunction

    function automatic t_in_item random_frame_op();
        t_in_item op;
        int lim;
        int pick;
        int sel;
        lim = (int'(total_now) > MAX_FRAMES) ? MAX_FRAMES : int'(total_now);
        op.byte_addr   = $urandom;
        op.first_frame = pick_frame(lim);
        op.end_frame   = FRAME_W'($urandom_range(0, END_MAX));
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op.func = FUNC_MARK_ALL;
        else if (pick < 18)
            op.func = FUNC_RELEASE;
        else if (pick < 28)
            op.func = FUNC_RESERVE;
        else if (pick < 53)
            op.func = FUNC_ALLOC;
        else if (pick < 73)
            op.func = FUNC_FREE;
        else if (pick < 96)
            op.func = FUNC_QUERY;
        else
            op.func = $urandom_range(0, 1) ? FUNC_UNUSED_A : FUNC_UNUSED_B;

        if (op.func == FUNC_RELEASE || op.func == FUNC_RESERVE) begin
            // Short ranges mostly, some empty or inverted, a few to the end
            sel = $urandom_range(0, 99);
            if (sel < 80)
                op.end_frame = FRAME_W'(op.first_frame + $urandom_range(0, 96));
            else if (sel < 88)
                op.end_frame = FRAME_W'($urandom_range(0, op.first_frame));
            else if (sel < 95)
                op.end_frame = $urandom_range(0, 1) ? END_MAX : FRAME_W'(lim);
        end
        if (op.func == FUNC_FREE && $urandom_range(0, 3) != 0)
            op.byte_addr = {pick_frame(lim), 12'($urandom)};
        return op;
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_frame_op(input t_in_item op);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write the register only once every result has come back
    task automatic write_frame_count(input logic [FRAME_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_total <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        total_now = value;
    endtask

    initial begin
        logic [FRAME_W-1:0] totals [6];
        logic [FRAME_W-1:0] total_sel;
        int n_items;

        totals = '{21'd0, 21'd1, END_MAX, 21'd33, 21'd32, 21'd32768};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner requests against the reset frame count, bitmap all used
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'hFFFFF, 21'd0));
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'd32767, 21'd0));
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'd32768, 21'd0));
        send_frame_op(frame_op(FUNC_ALLOC, 32'h0, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_RELEASE, 32'h0, 20'd0, 21'd64));
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'd5, 21'd0));
        send_frame_op(frame_op(FUNC_ALLOC, 32'h0, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_ALLOC, 32'h0, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_FREE, 32'h0000_1ABC, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_FREE, 32'hFFFF_FFFF, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_FREE, 32'h0000_5000, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_RESERVE, 32'h0, 20'd10, 21'd5));
        send_frame_op(frame_op(FUNC_RELEASE, 32'h0, 20'd20, 21'd20));
        send_frame_op(frame_op(FUNC_RESERVE, 32'h0, 20'd40, END_MAX));
        send_frame_op(frame_op(FUNC_RELEASE, 32'h0, 20'd32760, END_MAX));
        send_frame_op(frame_op(FUNC_RELEASE, 32'h0, 20'hFFFFF, END_MAX));
        send_frame_op(frame_op(FUNC_UNUSED_A, $urandom, 20'($urandom), 21'($urandom)));
        send_frame_op(frame_op(FUNC_UNUSED_B, $urandom, 20'($urandom), 21'($urandom)));
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'd32765, 21'd0));
        send_frame_op(frame_op(FUNC_ALLOC, 32'h0, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_MARK_ALL, 32'h0, 20'd0, 21'd0));
        send_frame_op(frame_op(FUNC_QUERY, 32'h0, 20'd32765, 21'd0));
        send_frame_op(frame_op(FUNC_RELEASE, 32'h0, 20'd0, END_MAX));
        send_frame_op(frame_op(FUNC_ALLOC, 32'h0, 20'd0, 21'd0));

        // Random mixes over fixed extremes first, then random frame counts
        for (int phase = 0; phase < 12; phase++) begin
            if (phase < 6)
                total_sel = totals[phase];
            else if ($urandom_range(0, 3) == 0)
                total_sel = FRAME_W'($urandom_range(2049, END_MAX));
            else
                total_sel = FRAME_W'($urandom_range(2, 2048));
            write_frame_count(total_sel);
            n_items = (total_sel == '0) ? 30 : PHASE_ITEMS;
            repeat (n_items) send_frame_op(random_frame_op());
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
